FILE: design/assert_macros.svh
// assertion macros used by the frame parser core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/slcfp_pkg.sv
// types, constants and the crc step shared by the frame parser modules
package slcfp_pkg;

   localparam logic [7:0]  SYNC_A    = 8'h55;
   localparam logic [7:0]  SYNC_B    = 8'hAA;
   localparam logic [15:0] CRC_POLY  = 16'h8408;
   localparam int          HEAD_LEN  = 8;
   localparam int          CRC_LEN   = 2;
   localparam int          HDR_BYTES = 6;
   localparam int          HDR_KEEP  = 4;

   typedef enum logic [1:0] {
      STATUS_BUSY  = 2'd0,
      STATUS_GOOD  = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_SYNC2   = 3'd1,
      PH_HEADER  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CRC1    = 3'd4,
      PH_CRC2    = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      DR_IDLE = 2'd0,
      DR_READ = 2'd1,
      DR_SEND = 2'd2
   } drain_type;

   typedef struct packed {
      status_type  status;
      logic        data_valid;
      logic [7:0]  payload_byte;
      logic [15:0] command;
      logic [6:0]  payload_length;
      logic        last;
   } rsp_beat_type;

   typedef struct packed {
      logic       en;
      logic [6:0] idx;
      logic [7:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic        start;
      logic [6:0]  count;
      logic [15:0] command;
   } drain_cmd_type;

   // reflected crc-16, one byte, lsb first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: design/slcfp_if.sv
// handshake channels for received bytes and result beats
interface slcfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        data_valid;
   logic [7:0]  payload_byte;
   logic [15:0] command;
   logic [6:0]  payload_length;
   logic        last;

   modport source (output valid, output status, output data_valid, output payload_byte,
                   output command, output payload_length, output last, input ready);
   modport sink (input valid, input status, input data_valid, input payload_byte,
                 input command, input payload_length, input last, output ready);
endinterface

FILE: design/slcfp_parse.sv
// sync hunt, header capture, payload write and crc check
module slcfp_parse #(
   parameter int PAYLOAD_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_fire,
   input  logic [7:0]                rx_byte,
   output slcfp_pkg::rsp_beat_type   beat,
   output logic                      beat_valid,
   output slcfp_pkg::mem_wr_type     wr,
   output slcfp_pkg::drain_cmd_type  drain
);

   slcfp_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  header_count_ff, header_count_in;
   logic [6:0]  payload_count_ff, payload_count_in;
   logic [6:0]  expected_ff, expected_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_high_ff, crc_high_in;
   logic [7:0]  hdr_ff [0:slcfp_pkg::HDR_KEEP-1];
   logic        hdr_we;
   logic [15:0] total;
   logic [15:0] plen;
   logic [15:0] rx_crc;
   logic [15:0] cmd;
   logic        clear;

   assign total  = {hdr_ff[0], hdr_ff[1]};
   assign plen   = total - 16'(slcfp_pkg::HEAD_LEN + slcfp_pkg::CRC_LEN);
   assign rx_crc = {crc_high_ff, rx_byte};
   assign cmd    = {hdr_ff[2], hdr_ff[3]};
   assign hdr_we = in_fire && (phase_ff == slcfp_pkg::PH_HEADER)
                   && (header_count_ff < 3'(slcfp_pkg::HDR_KEEP));

   always_comb begin
      phase_in         = phase_ff;
      header_count_in  = header_count_ff;
      payload_count_in = payload_count_ff;
      expected_in      = expected_ff;
      crc_in           = crc_ff;
      crc_high_in      = crc_high_ff;
      clear            = 1'b0;
      beat.status         = slcfp_pkg::STATUS_BUSY;
      beat.data_valid     = 1'b0;
      beat.payload_byte   = 8'h00;
      beat.command        = 16'h0000;
      beat.payload_length = 7'd0;
      beat.last           = 1'b1;
      beat_valid    = in_fire;
      wr.en         = 1'b0;
      wr.idx        = payload_count_ff;
      wr.data       = rx_byte;
      drain.start   = 1'b0;
      drain.count   = expected_ff;
      drain.command = cmd;
      if (in_fire) begin
         case (phase_ff)
            slcfp_pkg::PH_IDLE: begin
               if (rx_byte == slcfp_pkg::SYNC_A) phase_in = slcfp_pkg::PH_SYNC2;
            end
            slcfp_pkg::PH_SYNC2: begin
               if (rx_byte == slcfp_pkg::SYNC_B) begin
                  phase_in        = slcfp_pkg::PH_HEADER;
                  header_count_in = 3'd0;
                  crc_in          = 16'h0000;
               end else begin
                  phase_in = slcfp_pkg::PH_IDLE;
               end
            end
            slcfp_pkg::PH_HEADER: begin
               header_count_in = header_count_ff + 3'd1;
               if (header_count_ff == 3'(slcfp_pkg::HDR_BYTES - 1)) begin
                  if (total < 16'(slcfp_pkg::HEAD_LEN + slcfp_pkg::CRC_LEN)
                      || plen > 16'(PAYLOAD_DEPTH)) begin
                     clear       = 1'b1;
                     beat.status = slcfp_pkg::STATUS_ERROR;
                  end else begin
                     expected_in      = plen[6:0];
                     payload_count_in = 7'd0;
                     phase_in = (plen == 16'h0000) ? slcfp_pkg::PH_CRC1
                                                   : slcfp_pkg::PH_PAYLOAD;
                  end
               end
            end
            slcfp_pkg::PH_PAYLOAD: begin
               if (payload_count_ff < expected_ff
                   && payload_count_ff < 7'(PAYLOAD_DEPTH)) begin
                  wr.en            = 1'b1;
                  payload_count_in = payload_count_ff + 7'd1;
                  crc_in           = slcfp_pkg::crc16_byte(crc_ff, rx_byte);
                  if (payload_count_in == expected_ff) phase_in = slcfp_pkg::PH_CRC1;
               end else begin
                  clear       = 1'b1;
                  beat.status = slcfp_pkg::STATUS_ERROR;
               end
            end
            slcfp_pkg::PH_CRC1: begin
               crc_high_in = rx_byte;
               phase_in    = slcfp_pkg::PH_CRC2;
            end
            slcfp_pkg::PH_CRC2: begin
               clear = 1'b1;
               if (rx_crc != crc_ff) begin
                  beat.status = slcfp_pkg::STATUS_ERROR;
               end else if (expected_ff == 7'd0) begin
                  beat.status  = slcfp_pkg::STATUS_GOOD;
                  beat.command = cmd;
               end else begin
                  // payload goes out of the buffer, no beat from here
                  drain.start = 1'b1;
                  beat_valid  = 1'b0;
               end
            end
            default: begin
               clear = 1'b1;
            end
         endcase
      end
      if (clear) begin
         phase_in         = slcfp_pkg::PH_IDLE;
         header_count_in  = 3'd0;
         payload_count_in = 7'd0;
         expected_in      = 7'd0;
         crc_in           = 16'h0000;
         crc_high_in      = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= slcfp_pkg::PH_IDLE;
         header_count_ff  <= 3'd0;
         payload_count_ff <= 7'd0;
         expected_ff      <= 7'd0;
         crc_ff           <= 16'h0000;
         crc_high_ff      <= 8'h00;
      end else begin
         phase_ff         <= phase_in;
         header_count_ff  <= header_count_in;
         payload_count_ff <= payload_count_in;
         expected_ff      <= expected_in;
         crc_ff           <= crc_in;
         crc_high_ff      <= crc_high_in;
      end
   end

   // length and command bytes only, reserved bytes are dropped
   always_ff @(posedge clock) begin
      if (hdr_we) hdr_ff[header_count_ff[1:0]] <= rx_byte;
   end

endmodule

FILE: design/slcfp_store.sv
// payload memory and the sequencer that reads a good frame back out
module slcfp_store #(
   parameter int PAYLOAD_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  slcfp_pkg::mem_wr_type     wr,
   input  slcfp_pkg::drain_cmd_type  drain,
   input  logic                      out_free,
   output slcfp_pkg::rsp_beat_type   beat,
   output logic                      beat_valid,
   output logic                      busy
);

   localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

   logic [7:0] mem [0:PAYLOAD_DEPTH-1];
   logic [7:0] rd_data_ff;
   logic       rd_en;

   slcfp_pkg::drain_type state_ff, state_in;
   logic [6:0]  idx_ff, idx_in;
   logic [6:0]  count_ff, count_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [6:0]  idx_next;
   logic        final_beat;

   assign idx_next   = idx_ff + 7'd1;
   assign final_beat = (idx_next == count_ff);
   assign busy       = (state_ff != slcfp_pkg::DR_IDLE);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      cmd_in     = cmd_ff;
      rd_en      = 1'b0;
      beat_valid = 1'b0;
      beat.status         = slcfp_pkg::STATUS_GOOD;
      beat.data_valid     = 1'b1;
      beat.payload_byte   = rd_data_ff;
      beat.command        = cmd_ff;
      beat.payload_length = count_ff;
      beat.last           = final_beat;
      case (state_ff)
         slcfp_pkg::DR_IDLE: begin
            if (drain.start) begin
               state_in = slcfp_pkg::DR_READ;
               idx_in   = 7'd0;
               count_in = drain.count;
               cmd_in   = drain.command;
            end
         end
         slcfp_pkg::DR_READ: begin
            rd_en    = 1'b1;
            state_in = slcfp_pkg::DR_SEND;
         end
         slcfp_pkg::DR_SEND: begin
            // read data holds until the output slot opens
            if (out_free) begin
               beat_valid = 1'b1;
               idx_in     = idx_next;
               state_in   = final_beat ? slcfp_pkg::DR_IDLE : slcfp_pkg::DR_READ;
            end
         end
         default: begin
            state_in = slcfp_pkg::DR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slcfp_pkg::DR_IDLE;
         idx_ff   <= 7'd0;
         count_ff <= 7'd0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.idx[AW-1:0]] <= wr.data;
      if (rd_en) rd_data_ff <= mem[idx_ff[AW-1:0]];
   end

endmodule

FILE: design/sync_length_crc16_frame_parser_core.sv
// latency: the result beat of an accepted byte is registered and offered the next cycle
// throughput: one byte a cycle through sync, header, payload and crc while the result output is free
// a good frame with n payload bytes sends n beats, each read then sent, through the one memory read port
// no byte is taken while a frame drains
// synchronous reset returns to sync hunt and drops any pending beat, payload memory kept
module sync_length_crc16_frame_parser_core #(
   parameter int PAYLOAD_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   slcfp_req_if.sink          req_bus,
   slcfp_rsp_if.source        rsp_bus
);

   `include "assert_macros.svh"

   slcfp_pkg::rsp_beat_type  parse_beat;
   slcfp_pkg::rsp_beat_type  drain_beat;
   slcfp_pkg::rsp_beat_type  rsp_beat_ff;
   slcfp_pkg::mem_wr_type    wr;
   slcfp_pkg::drain_cmd_type drain;
   logic parse_valid;
   logic drain_valid;
   logic drain_busy;
   logic out_free;
   logic in_fire;
   logic rsp_valid_ff, rsp_valid_in;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !drain_busy && out_free;
   assign in_fire       = req_bus.valid && req_bus.ready;

   slcfp_parse #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_parse (
      .clock      (clock),
      .reset      (reset),
      .in_fire    (in_fire),
      .rx_byte    (req_bus.rx_byte),
      .beat       (parse_beat),
      .beat_valid (parse_valid),
      .wr         (wr),
      .drain      (drain)
   );

   slcfp_store #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .drain      (drain),
      .out_free   (out_free),
      .beat       (drain_beat),
      .beat_valid (drain_valid),
      .busy       (drain_busy)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (parse_valid || drain_valid) rsp_valid_in = 1'b1;
      else if (rsp_bus.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (drain_valid) rsp_beat_ff <= drain_beat;
      else if (parse_valid) rsp_beat_ff <= parse_beat;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_beat_ff.status;
   assign rsp_bus.data_valid     = rsp_beat_ff.data_valid;
   assign rsp_bus.payload_byte   = rsp_beat_ff.payload_byte;
   assign rsp_bus.command        = rsp_beat_ff.command;
   assign rsp_bus.payload_length = rsp_beat_ff.payload_length;
   assign rsp_bus.last           = rsp_beat_ff.last;

   `ASSERT_SAME(a_one_source, clock, reset, parse_valid, !drain_valid, "parser and drain beats collide")
   `ASSERT_NEXT(a_drain_starts, clock, reset, drain.start, drain_busy, "drain did not start")
   `ASSERT_SAME(a_error_shape, clock, reset, rsp_valid_ff && rsp_beat_ff.status == slcfp_pkg::STATUS_ERROR, rsp_beat_ff.last && !rsp_beat_ff.data_valid, "error beat malformed")
   `ASSERT_SAME(a_data_len, clock, reset, rsp_valid_ff && rsp_beat_ff.data_valid, rsp_beat_ff.payload_length != 7'd0 && rsp_beat_ff.status == slcfp_pkg::STATUS_GOOD, "payload beat without length")

endmodule

FILE: test/slcfp_frame_checker.sv
`timescale 1ns / 100ps
// frame parser checker: predicts result beats from accepted bytes and compares them
module slcfp_frame_checker
   import slcfp_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = 64
) (
   input  logic  clock,
   input  logic  reset,
   slcfp_req_if  req_mon,
   slcfp_rsp_if  rsp_mon,
   output int    fail_count,
   output int    pending_beats
);

   // parser state, mirrored
   phase_type    phase;
   logic [2:0]   hdr_count;
   logic [7:0]   hdr_bytes [HDR_BYTES];
   logic [6:0]   pay_count;
   logic [6:0]   pay_len;
   logic [15:0]  crc_acc;
   logic [7:0]   crc_hi;
   logic [7:0]   pay_bytes [PAYLOAD_DEPTH];

   rsp_beat_type beat_q [$];

   // reflected crc-16 one bit at a time, data lsb first
   function automatic logic [15:0] kermit_step(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] r;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         if (r[0] ^ data[k]) r = (r >> 1) ^ CRC_POLY;
         else r = r >> 1;
      end
      return r;
   endfunction

   function automatic void push_beat(input status_type st, input logic dv, input logic [7:0] pb,
                                     input logic [15:0] cmd, input logic [6:0] len,
                                     input logic lst);
      rsp_beat_type nb;
      nb.status         = st;
      nb.data_valid     = dv;
      nb.payload_byte   = pb;
      nb.command        = cmd;
      nb.payload_length = len;
      nb.last           = lst;
      beat_q.push_back(nb);
   endfunction

   function automatic string beat_text(input rsp_beat_type x);
      return $sformatf("status %0d dv %0d byte %02h cmd %04h len %0d last %0d", x.status,
                       x.data_valid, x.payload_byte, x.command, x.payload_length, x.last);
   endfunction

   function automatic void clear_frame();
      phase     = PH_IDLE;
      hdr_count = '0;
      pay_count = '0;
      pay_len   = '0;
      crc_acc   = '0;
      crc_hi    = '0;
   endfunction

   function automatic void predict_byte(input logic [7:0] b);
      logic [15:0] total;
      logic [15:0] cmd;
      bit          done;
      done = 0;
      case (phase)
         PH_IDLE: begin
            if (b == SYNC_A) phase = PH_SYNC2;
         end
         PH_SYNC2: begin
            if (b == SYNC_B) begin
               phase     = PH_HEADER;
               hdr_count = '0;
               crc_acc   = '0;
            end else begin
               phase = PH_IDLE;
            end
         end
         PH_HEADER: begin
            hdr_bytes[hdr_count] = b;
            hdr_count++;
            if (hdr_count == HDR_BYTES) begin
               total = {hdr_bytes[0], hdr_bytes[1]};
               if (total < HEAD_LEN + CRC_LEN ||
                   total - HEAD_LEN - CRC_LEN > PAYLOAD_DEPTH) begin
                  clear_frame();
                  push_beat(STATUS_ERROR, 1'b0, 8'h00, 16'h0000, 7'd0, 1'b1);
                  done = 1;
               end else begin
                  pay_len   = 7'(total - HEAD_LEN - CRC_LEN);
                  pay_count = '0;
                  phase     = (pay_len == 0) ? PH_CRC1 : PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            pay_bytes[pay_count] = b;
            pay_count++;
            crc_acc = kermit_step(crc_acc, b);
            if (pay_count == pay_len) phase = PH_CRC1;
         end
         PH_CRC1: begin
            crc_hi = b;
            phase  = PH_CRC2;
         end
         PH_CRC2: begin
            cmd = {hdr_bytes[2], hdr_bytes[3]};
            if ({crc_hi, b} != crc_acc) begin
               push_beat(STATUS_ERROR, 1'b0, 8'h00, 16'h0000, 7'd0, 1'b1);
            end else if (pay_len == 0) begin
               push_beat(STATUS_GOOD, 1'b0, 8'h00, cmd, 7'd0, 1'b1);
            end else begin
               for (int i = 0; i < pay_len; i++) begin
                  push_beat(STATUS_GOOD, 1'b1, pay_bytes[i], cmd, pay_len, i == pay_len - 1);
               end
            end
            clear_frame();
            done = 1;
         end
         default: clear_frame();
      endcase
      if (!done) push_beat(STATUS_BUSY, 1'b0, 8'h00, 16'h0000, 7'd0, 1'b1);
   endfunction

   always @(posedge clock) begin
      rsp_beat_type want;
      rsp_beat_type got;
      if (reset) begin
         beat_q.delete();
         clear_frame();
      end else begin
         // the beat taken at this edge belongs to an earlier byte, so compare first
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.status, rsp_mon.data_valid, rsp_mon.payload_byte, rsp_mon.command,
                   rsp_mon.payload_length, rsp_mon.last};
            if (beat_q.size() == 0) begin
               if (fail_count < 10) $display("%0t: unexpected beat: %s", $time, beat_text(got));
               fail_count++;
            end else begin
               want = beat_q.pop_front();
               if (got.status !== want.status || got.data_valid !== want.data_valid ||
                   got.payload_byte !== want.payload_byte || got.command !== want.command ||
                   got.payload_length !== want.payload_length || got.last !== want.last) begin
                  if (fail_count < 10) begin
                     $display("%0t: beat mismatch: expected %s, got %s", $time,
                              beat_text(want), beat_text(got));
                  end
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) predict_byte(req_mon.rx_byte);
      end
      pending_beats = beat_q.size();
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// top of the frame parser bench: clock, reset, byte stimulus, result backpressure, verdict
module testbench;
   import slcfp_pkg::*;

   localparam int PAYLOAD_DEPTH = 64;
   localparam int MAX_TOTAL     = HEAD_LEN + CRC_LEN + PAYLOAD_DEPTH;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_beats;
   int   bytes_sent = 0;
   bit   burst = 0;

   slcfp_req_if req_bus ();
   slcfp_rsp_if rsp_bus ();

   sync_length_crc16_frame_parser_core #(
      .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   slcfp_frame_checker #(
      .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_beats (pending_beats)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // called and returns at a falling edge; valid stays up across back-to-back bytes
   task automatic put_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   // fill < 0 gives random payload bytes; keep >= 0 cuts the frame after that many bytes
   task automatic send_frame(input logic [15:0] total, input logic [15:0] cmd, input int fill,
                             input logic [15:0] crc_flip, input int keep);
      logic [7:0]  frame_q [$];
      logic [7:0]  b;
      logic [15:0] crc;
      int          n;
      crc     = '0;
      frame_q = '{SYNC_A, SYNC_B, total[15:8], total[7:0], cmd[15:8], cmd[7:0],
                  8'($urandom), 8'($urandom)};
      if (total >= HEAD_LEN + CRC_LEN && total <= MAX_TOTAL) begin
         n = total - HEAD_LEN - CRC_LEN;
         repeat (n) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            frame_q.push_back(b);
            crc = crc16_byte(crc, b);
         end
         crc ^= crc_flip;
         frame_q.push_back(crc[15:8]);
         frame_q.push_back(crc[7:0]);
      end
      if (keep < 0 || keep > frame_q.size()) keep = frame_q.size();
      for (int i = 0; i < keep; i++) put_byte(frame_q[i]);
   endtask

   initial begin : stimulus
      int          pick;
      int          plen;
      logic [15:0] total;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // sync hunt: stray bytes, a doubled first sync, a lone second sync
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(SYNC_A);
      put_byte(SYNC_A);
      put_byte(SYNC_B);
      put_byte(SYNC_A);
      put_byte(8'h12);

      send_frame(16'd10, 16'hFFFF, 0, 16'h0000, -1);     // empty payload, good
      send_frame(16'd10, 16'h1234, 0, 16'h0001, -1);     // empty payload, crc not zero
      send_frame(16'd0, 16'h0000, 0, 16'h0000, -1);      // total below header size
      send_frame(16'd9, 16'hFFFF, 0, 16'h0000, -1);
      send_frame(16'(MAX_TOTAL + 1), 16'h0F0F, 0, 16'h0000, -1);  // one byte over depth
      send_frame(16'hFFFF, 16'hF0F0, 0, 16'h0000, -1);
      send_frame(16'd11, 16'h0000, 8'hFF, 16'h0000, -1);
      send_frame(16'd11, 16'hA5A5, 8'h00, 16'h8000, -1); // crc mismatch
      send_frame(16'(MAX_TOTAL), 16'h5AA5, -1, 16'h0000, -1);

      while (bytes_sent < 500) begin
         burst = ($urandom_range(0, 3) == 0);
         pick  = $urandom_range(0, 99);
         plen  = ($urandom_range(0, 19) == 0) ? PAYLOAD_DEPTH : $urandom_range(0, 10);
         total = 16'(plen + HEAD_LEN + CRC_LEN);
         if (pick < 70) begin
            send_frame(total, 16'($urandom), -1, 16'h0000, -1);
         end else if (pick < 80) begin
            send_frame(total, 16'($urandom), -1, 16'($urandom_range(1, 16'hFFFF)), -1);
         end else if (pick < 87) begin
            total = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 9))
                                                : 16'($urandom_range(MAX_TOTAL + 1, 65535));
            send_frame(total, 16'($urandom), -1, 16'h0000, -1);
         end else if (pick < 94) begin
            // cut short, the next frame runs into the header, payload or crc of this one, unless it is sent whole
            send_frame(total, 16'($urandom), -1, 16'h0000, $urandom_range(3, plen + 11));
         end else begin
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
         end
      end
      req_bus.valid <= 1'b0;

      wait (pending_beats == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin : rsp_ready_gen
      int mode;
      int span;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      repeat (100) @(negedge clock) rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      // long hold-off while bytes keep coming, so the block backs up and stalls its input
      @(negedge clock) rsp_bus.ready <= 1'b0;
      repeat (300) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 9);
         span = $urandom_range(10, 60);
         repeat (span) begin
            @(negedge clock);
            if (mode < 4) rsp_bus.ready <= 1'b1;
            else if (mode < 9) rsp_bus.ready <= ($urandom_range(0, 2) != 0);
            else rsp_bus.ready <= 1'b0;
         end
      end
   end

   initial begin : run_limit
      #100_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
